// File: rtl/oal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types for the ordered array list engine: action codes and payloads.
// ----------------------------------------------------------------------------
package oal_pkg;

  typedef enum logic [2:0] {
    ACT_APPEND  = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_REM_IDX = 3'd2,
    ACT_REM_VAL = 3'd3,
    ACT_FIND    = 3'd4,
    ACT_GET     = 3'd5,
    ACT_SET     = 3'd6,
    ACT_CLEAR   = 3'd7
  } oal_action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [8:0]  position;
    logic [31:0] item_word;
  } oal_in_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_word;
    logic [7:0]  found_at;
    logic [8:0]  entry_count;
  } oal_out_t;

  // decoded command as queued between front and back
  typedef struct packed {
    oal_action_e action;
    logic [8:0]  position;
    logic [31:0] item_word;
  } oal_cmd_t;

endpackage

// File: rtl/ordered_array_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_engine_unit
// Ordered list of words with append, insert, remove, find, get, set, clear.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per transfer (action, position, item_word).
//   out_* : exactly one result per request, in request order.
//   Requests land in a two-entry queue, so the input keeps taking transfers
//   while a result waits to be taken, until the queue is full.
// Operation per request (n = entry count, RAM has a registered read port):
//   append, set, clear and failed checks: result set straight from idle.
//   get: one registered RAM read, then the result.
//   insert at p: the n - p entries from p up moved one per cycle, then the write.
//   remove at p: the entries above p shifted down; find/remove value: a scan
//   from index 0 to the first match, plus the shift for a removal.
//   The worst case is a walk over the whole list, up to CAPACITY entries.
// Reset clears the count and all handshake state; the entry RAM is not
//   cleared, entries beyond the count are never used.
// A stalled output holds the result; no new request starts until it goes.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_unit import oal_pkg::*; #(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  oal_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output oal_out_t out_data_o
);

  logic     cmd_valid;
  logic     cmd_pop;
  oal_cmd_t cmd;

  oal_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  oal_back #(.CAPACITY(CAPACITY), .WORD_BITS(WORD_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: rtl/oal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module oal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/oal_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_front
// Input side: takes request transfers, decodes the action and holds them in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module oal_front import oal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  oal_in_t  in_data_i,
  output logic     cmd_valid_o,
  output oal_cmd_t cmd_o,
  input  logic     cmd_pop_i
);

  oal_cmd_t   slot_q [2];
  logic [1:0] fill_q, fill_d;
  logic       rp_q, rp_d, wp_q, wp_d;
  logic       push, pop;
  oal_cmd_t   dec;

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rp_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = cmd_pop_i & cmd_valid_o;

  always_comb begin
    dec.action    = oal_action_e'(in_data_i.action);
    dec.position  = in_data_i.position;
    dec.item_word = in_data_i.item_word;
  end

  always_comb begin
    fill_d = fill_q;
    rp_d   = rp_q;
    wp_d   = wp_q;
    if (push) begin
      wp_d = ~wp_q;
    end
    if (pop) begin
      rp_d = ~rp_q;
    end
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      rp_q   <= 1'b0;
      wp_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      rp_q   <= rp_d;
      wp_q   <= wp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= dec;
    end
  end

endmodule

// File: rtl/oal_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_back
// Execution side: runs one command at a time against the entry RAM, walking
// entries one per cycle for shifts and searches, and holds the result.
// ----------------------------------------------------------------------------
module oal_back import oal_pkg::*; #(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  oal_cmd_t cmd_i,
  output logic     cmd_pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output oal_out_t out_data_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > 9) ? CW : 9;
  localparam int XW = EW + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_DN   = 6'b000100,
    ST_UP   = 6'b001000,
    ST_NEW  = 6'b010000,
    ST_GET  = 6'b100000
  } oal_state_e;

  oal_state_e     st_q, st_d;
  logic [CW-1:0]  cnt_q, cnt_d, dst_q, dst_d;
  oal_cmd_t       cmd_q, cmd_d;
  logic           ovld_q, ovld_d;
  oal_out_t       res_q, res_d;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  logic                 fin, ok_w;
  logic [31:0]          rd_w;
  logic [7:0]           fa_w;
  logic [XW-1:0]        cnt_x, dst_x, hpos_x, qpos_x;
  logic [WORD_BITS-1:0] hword, qword;

  oal_ram #(.WIDTH(WORD_BITS), .DEPTH(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign cnt_x  = XW'(cnt_q);
  assign dst_x  = XW'(dst_q);
  assign hpos_x = XW'(cmd_i.position);
  assign qpos_x = XW'(cmd_q.position);
  assign hword  = WORD_BITS'(cmd_i.item_word);
  assign qword  = WORD_BITS'(cmd_q.item_word);

  assign out_valid_o = ovld_q;
  assign out_data_o  = res_q;

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    dst_d     = dst_q;
    cmd_d     = cmd_q;
    ovld_d    = ovld_q & ~out_ready_i;
    res_d     = res_q;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    waddr     = AW'(cnt_q);
    wdata     = hword;
    raddr     = '0;
    fin       = 1'b0;
    ok_w      = 1'b0;
    rd_w      = '0;
    fa_w      = '0;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i && !ovld_q) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.action)
            ACT_APPEND: begin
              fin = 1'b1;
              if (hword != '0 && cnt_x < XW'(CAPACITY)) begin
                we    = 1'b1;
                cnt_d = CW'(cnt_x + 1'b1);
                ok_w  = 1'b1;
              end
            end
            ACT_INSERT: begin
              if (hword != '0 && hpos_x <= cnt_x && cnt_x < XW'(CAPACITY)) begin
                if (hpos_x == cnt_x) begin
                  we    = 1'b1;
                  cnt_d = CW'(cnt_x + 1'b1);
                  ok_w  = 1'b1;
                  fin   = 1'b1;
                end else begin
                  raddr = AW'(cnt_x - 1'b1);
                  dst_d = cnt_q;
                  st_d  = ST_UP;
                end
              end else begin
                fin = 1'b1;
              end
            end
            ACT_REM_IDX: begin
              if (hpos_x < cnt_x) begin
                if (hpos_x + 1'b1 < cnt_x) begin
                  raddr = AW'(hpos_x + 1'b1);
                  dst_d = CW'(hpos_x);
                  st_d  = ST_DN;
                end else begin
                  cnt_d = CW'(cnt_x - 1'b1);
                  ok_w  = 1'b1;
                  fin   = 1'b1;
                end
              end else begin
                fin = 1'b1;
              end
            end
            ACT_REM_VAL, ACT_FIND: begin
              if (cnt_q == '0) begin
                fin = 1'b1;
              end else begin
                raddr = '0;
                dst_d = '0;
                st_d  = ST_SCAN;
              end
            end
            ACT_GET: begin
              if (hpos_x < cnt_x) begin
                raddr = AW'(hpos_x);
                st_d  = ST_GET;
              end else begin
                fin = 1'b1;
              end
            end
            ACT_SET: begin
              fin = 1'b1;
              if (hpos_x < cnt_x) begin
                we    = 1'b1;
                waddr = AW'(hpos_x);
                ok_w  = 1'b1;
              end
            end
            default: begin
              cnt_d = '0;
              ok_w  = 1'b1;
              fin   = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // read of the next entry goes out every cycle; it feeds the shift on a match
        raddr = AW'(dst_x + 1'b1);
        if (rdata == qword) begin
          if (cmd_q.action == ACT_FIND) begin
            ok_w = 1'b1;
            fa_w = 8'(dst_q);
            fin  = 1'b1;
            st_d = ST_IDLE;
          end else if (dst_x + 1'b1 < cnt_x) begin
            st_d = ST_DN;
          end else begin
            cnt_d = CW'(cnt_x - 1'b1);
            ok_w  = 1'b1;
            fin   = 1'b1;
            st_d  = ST_IDLE;
          end
        end else if (dst_x + 1'b1 == cnt_x) begin
          fin  = 1'b1;
          st_d = ST_IDLE;
        end else begin
          dst_d = CW'(dst_x + 1'b1);
        end
      end
      ST_DN: begin
        we    = 1'b1;
        waddr = AW'(dst_q);
        wdata = rdata;
        raddr = AW'(dst_x + 2'd2);
        if (dst_x + 2'd2 < cnt_x) begin
          dst_d = CW'(dst_x + 1'b1);
        end else begin
          cnt_d = CW'(cnt_x - 1'b1);
          ok_w  = 1'b1;
          fin   = 1'b1;
          st_d  = ST_IDLE;
        end
      end
      ST_UP: begin
        we    = 1'b1;
        waddr = AW'(dst_q);
        wdata = rdata;
        if (dst_x - 1'b1 > qpos_x) begin
          raddr = AW'(dst_x - 2'd2);
          dst_d = CW'(dst_x - 1'b1);
        end else begin
          st_d = ST_NEW;
        end
      end
      ST_NEW: begin
        we    = 1'b1;
        waddr = AW'(qpos_x);
        wdata = qword;
        cnt_d = CW'(cnt_x + 1'b1);
        ok_w  = 1'b1;
        fin   = 1'b1;
        st_d  = ST_IDLE;
      end
      ST_GET: begin
        rd_w = 32'(rdata);
        ok_w = 1'b1;
        fin  = 1'b1;
        st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
    if (fin) begin
      ovld_d            = 1'b1;
      res_d.ok          = ok_w;
      res_d.read_word   = rd_w;
      res_d.found_at    = fa_w;
      res_d.entry_count = 9'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q <= dst_d;
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(cnt_q) <= XW'(CAPACITY))
    else $error("entry count above capacity");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (st_q == ST_IDLE) && !ovld_q)
    else $error("command taken while busy");

  a_dn_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DN) |-> (XW'(dst_q) + 1'b1 < XW'(cnt_q)))
    else $error("shift down past end of list");

  a_up_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_UP) |-> (XW'(dst_q) > XW'(cmd_q.position)))
    else $error("shift up below insert position");

  a_busy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !ovld_q)
    else $error("result pending while command runs");

endmodule

// File: test/tb_ordered_array_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_array_list_engine_unit
// Drives list actions (append, insert, remove, find, get, set, clear) with
// random bursts and output stalls, predicts each result from a shadow list
// and compares every field of every result in order.
// ----------------------------------------------------------------------------
module tb_ordered_array_list_engine_unit;
  import oal_pkg::*;

  localparam int CAP = 256;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  oal_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  oal_out_t out_data_o;

  ordered_array_list_engine_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // shadow of the list
  logic [31:0] list_words [CAP];
  int          list_len;
  // list length as seen by the generator, kept in step with the shadow
  int          gen_len;
  logic [31:0] gen_words [$];

  oal_in_t  pending_reqs [$];
  oal_out_t expected_results [$];
  int       n_errors;
  int       n_results;
  int       n_sent;
  int       act_seen [8];
  longint   cycle_count;
  bit       stim_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic oal_out_t apply_action(oal_in_t req);
    oal_out_t res;
    int       hit;
    res = '0;
    hit = -1;
    case (oal_action_e'(req.action))
      ACT_APPEND: begin
        if (req.item_word != 0 && list_len < CAP) begin
          list_words[list_len] = req.item_word;
          list_len++;
          res.ok = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (req.item_word != 0 && req.position <= list_len && list_len < CAP) begin
          for (int i = list_len; i > req.position; i--) list_words[i] = list_words[i-1];
          list_words[req.position] = req.item_word;
          list_len++;
          res.ok = 1'b1;
        end
      end
      ACT_REM_IDX, ACT_REM_VAL: begin
        if (oal_action_e'(req.action) == ACT_REM_IDX) begin
          if (req.position < list_len) hit = req.position;
        end else begin
          for (int i = 0; i < list_len; i++)
            if (hit < 0 && list_words[i] == req.item_word) hit = i;
        end
        if (hit >= 0) begin
          for (int i = hit; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          res.ok = 1'b1;
        end
      end
      ACT_FIND: begin
        for (int i = 0; i < list_len; i++)
          if (hit < 0 && list_words[i] == req.item_word) hit = i;
        if (hit >= 0) begin
          res.ok       = 1'b1;
          res.found_at = hit[7:0];
        end
      end
      ACT_GET: begin
        if (req.position < list_len) begin
          res.read_word = list_words[req.position];
          res.ok        = 1'b1;
        end
      end
      ACT_SET: begin
        if (req.position < list_len) begin
          list_words[req.position] = req.item_word;
          res.ok = 1'b1;
        end
      end
      default: begin
        list_len = 0;
        res.ok   = 1'b1;
      end
    endcase
    res.entry_count = list_len[8:0];
    return res;
  endfunction

  // generator-side mirror so random values can target present words
  task automatic queue_req(oal_action_e act, int pos, logic [31:0] w);
    oal_in_t r;
    int      hit;
    r.action    = act;
    r.position  = pos[8:0];
    r.item_word = w;
    pending_reqs.push_back(r);
    hit = -1;
    case (act)
      ACT_APPEND: if (w != 0 && gen_len < CAP) begin gen_words.push_back(w); gen_len++; end
      ACT_INSERT: begin
        if (w != 0 && pos <= gen_len && gen_len < CAP) begin
          gen_words.insert(pos, w);
          gen_len++;
        end
      end
      ACT_REM_IDX: if (pos < gen_len) begin gen_words.delete(pos); gen_len--; end
      ACT_REM_VAL: begin
        foreach (gen_words[i]) if (hit < 0 && gen_words[i] == w) hit = i;
        if (hit >= 0) begin gen_words.delete(hit); gen_len--; end
      end
      ACT_SET: if (pos < gen_len) gen_words[pos] = w;
      ACT_CLEAR: begin gen_words.delete(); gen_len = 0; end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && gen_len > 0) return gen_words[$urandom_range(0, gen_len - 1)];
    if (sel == 4) return 32'd0;
    if (sel == 5) return 32'hFFFF_FFFF;
    if (sel < 8) return 32'($urandom_range(1, 8));
    return $urandom;
  endfunction

  function automatic int pick_pos();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 511);
    if (sel == 1) return gen_len;
    if (sel == 2) return gen_len + 1;
    return (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
  endfunction

  initial begin
    oal_action_e act;
    int          sel;
    gen_len = 0;
    // directed: empty-list failures, nulls, extremes, every action
    queue_req(ACT_GET, 0, 32'd0);
    queue_req(ACT_REM_IDX, 0, 32'd0);
    queue_req(ACT_FIND, 0, 32'd5);
    queue_req(ACT_REM_VAL, 0, 32'd5);
    queue_req(ACT_APPEND, 0, 32'd0);
    queue_req(ACT_INSERT, 0, 32'd0);
    queue_req(ACT_APPEND, 0, 32'hFFFF_FFFF);
    queue_req(ACT_INSERT, 0, 32'h0000_0001);
    queue_req(ACT_INSERT, 511, 32'h1234_5678);
    queue_req(ACT_INSERT, 2, 32'hAAAA_5555);
    queue_req(ACT_SET, 1, 32'd0);
    queue_req(ACT_FIND, 0, 32'd0);
    queue_req(ACT_GET, 1, 32'd0);
    queue_req(ACT_GET, 3, 32'd0);
    queue_req(ACT_SET, 511, 32'h5555_AAAA);
    queue_req(ACT_REM_VAL, 0, 32'd0);
    queue_req(ACT_FIND, 0, 32'hAAAA_5555);
    queue_req(ACT_REM_IDX, 1, 32'd0);
    queue_req(ACT_GET, 0, 32'd0);
    queue_req(ACT_CLEAR, 0, 32'd0);
    queue_req(ACT_GET, 0, 32'd0);
    // fill to capacity, hit the full case, find the last slot, then clear
    for (int i = 0; i < CAP; i++) queue_req(ACT_APPEND, 0, 32'(i + 1));
    queue_req(ACT_APPEND, 0, 32'd7);
    queue_req(ACT_INSERT, 0, 32'd7);
    queue_req(ACT_FIND, 0, 32'd256);
    queue_req(ACT_GET, 255, 32'd0);
    queue_req(ACT_INSERT, 3, 32'd99);
    queue_req(ACT_REM_IDX, 0, 32'd0);
    queue_req(ACT_INSERT, 3, 32'hDEAD_BEEF);
    queue_req(ACT_CLEAR, 0, 32'd0);
    // random part, weighted toward growth so lists get long
    for (int n = 0; n < 865; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 28) act = ACT_APPEND;
      else if (sel < 45) act = ACT_INSERT;
      else if (sel < 55) act = ACT_REM_IDX;
      else if (sel < 64) act = ACT_REM_VAL;
      else if (sel < 76) act = ACT_FIND;
      else if (sel < 88) act = ACT_GET;
      else if (sel < 98) act = ACT_SET;
      else act = ACT_CLEAR;
      queue_req(act, pick_pos(), pick_word());
    end
  end

  // driver: bursts and gaps
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        act_seen[in_data_i.action]++;
        expected_results.push_back(apply_action(in_data_i));
        n_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_reqs.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
          stim_done  <= 1'b1;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_o);
          n_errors++;
        end else begin : check_result
          oal_out_t exp_res;
          exp_res = expected_results.pop_front();
          if (exp_res !== out_data_o) begin
            $display("%0t: mismatch expected ok=%0b rd=%h at=%0d cnt=%0d",
                     $time, exp_res.ok, exp_res.read_word, exp_res.found_at,
                     exp_res.entry_count);
            $display("%0t:          actual   ok=%0b rd=%h at=%0d cnt=%0d",
                     $time, out_data_o.ok, out_data_o.read_word,
                     out_data_o.found_at, out_data_o.entry_count);
            n_errors++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 64;
      // free-flowing for a stretch, then random stalls
      if (stall_phase < 20) out_ready_i <= 1'b1;
      else if (stall_phase < 56) out_ready_i <= ($urandom_range(0, 2) != 0);
      else out_ready_i <= ($urandom_range(0, 4) == 0);
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_results.size() == 0);
    repeat (600) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results", n_sent, n_results);
    $display("per action: app %0d ins %0d rmi %0d rmv %0d fnd %0d get %0d set %0d clr %0d",
             act_seen[0], act_seen[1], act_seen[2], act_seen[3],
             act_seen[4], act_seen[5], act_seen[6], act_seen[7]);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// File: filelist.f
rtl/oal_pkg.sv
rtl/oal_ram.sv
rtl/oal_front.sv
rtl/oal_back.sv
rtl/ordered_array_list_engine_unit.sv
test/tb_ordered_array_list_engine_unit.sv
